FILE: hw/rtl/ptg_pkg.sv
package ptg_pkg;

  // default table depth
  localparam int unsigned NumPortsDef = 8;

  // fixed one-second rate window in milliseconds
  localparam logic [31:0] WindowMs = 32'd1000;

  // request action codes
  localparam logic [2:0] ActAdd      = 3'd0;
  localparam logic [2:0] ActUplink   = 3'd1;
  localparam logic [2:0] ActDownlink = 3'd2;
  localparam logic [2:0] ActRead     = 3'd3;
  localparam logic [2:0] ActClear    = 3'd4;

  // statistic counter slots
  localparam int unsigned StatCount   = 6;
  localparam int unsigned StatUpIn    = 0;
  localparam int unsigned StatUpDrop  = 1;
  localparam int unsigned StatUpPub   = 2;
  localparam int unsigned StatDnIn    = 3;
  localparam int unsigned StatDnDrop  = 4;
  localparam int unsigned StatDnSent  = 5;

  // one port table entry
  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  kind;
    logic        can_send;
    logic [15:0] cap;
    logic [31:0] win_start;
    logic [15:0] count;
  } entry_t;

  // table write command
  typedef struct packed {
    logic en;
    logic alloc;
    logic clear;
  } tbl_cmd_t;

endpackage

FILE: hw/rtl/port_table_rate_limited_gateway_unit.sv
// Port table gateway with a per-port uplink rate cap. A request is taken at a
// rising edge with start_i high and busy_o low; its single result appears on
// the result ports for exactly one cycle with done_o high, and the receiver
// cannot hold it off, so capture it on that cycle. Add, uplink and downlink
// requests scan the port table one entry per cycle through its single read
// port, then run the window check and the update: done_o rises NumPorts + 3
// cycles after the accepting edge, and a new request may be taken on the edge
// that ends the done_o cycle, so such a request occupies NumPorts + 4 cycles.
// Read, clear and unknown actions raise done_o one cycle after the accepting
// edge and occupy two cycles. The sink-installed register is written with
// cfg_we_i while idle.
module port_table_rate_limited_gateway_unit import ptg_pkg::*; #(
  parameter int unsigned NumPorts = NumPortsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         action_i,
  input  logic [7:0]         port_id_i,
  input  logic [15:0]        node_addr_i,
  input  logic [15:0]        payload_len_i,
  input  logic signed [15:0] signal_rssi_i,
  input  logic [31:0]        now_ms_i,
  input  logic [15:0]        cap_per_second_i,
  input  logic [7:0]         kind_code_i,
  input  logic               has_transmitter_i,
  input  logic               sink_accepts_i,
  input  logic [2:0]         counter_select_i,
  output logic               done_o,
  output logic               ok_o,
  output logic               admitted_o,
  output logic [31:0]        seq_number_o,
  output logic [7:0]         out_port_id_o,
  output logic [15:0]        out_addr_o,
  output logic [15:0]        out_len_o,
  output logic signed [15:0] out_rssi_o,
  output logic [7:0]         out_kind_o,
  output logic [31:0]        counter_value_o
);

  localparam int unsigned IdxW = (NumPorts > 1) ? $clog2(NumPorts) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NumPorts - 1);

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StScan   = 4'b0010,
    StWindow = 4'b0100,
    StDecide = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // captured request
  logic [2:0]         act_q;
  logic [7:0]         pid_q;
  logic [15:0]        addr_q;
  logic [15:0]        len_q;
  logic signed [15:0] rssi_q;
  logic [31:0]        now_q;
  logic [15:0]        cap_q;
  logic [7:0]         kind_q;
  logic               tx_q;
  logic               accept_q;
  logic [2:0]         sel_q;

  // scan bookkeeping
  logic [IdxW-1:0] rd_idx_q;
  logic            issue_done_q;
  logic            cmp_vld_q;
  logic [IdxW-1:0] cmp_idx_q;
  logic            hit_q;
  logic [IdxW-1:0] hit_idx_q;
  entry_t          hit_ent_q;
  logic            free_q;
  logic [IdxW-1:0] free_idx_q;

  // window stage
  logic [31:0] win_q;
  logic [15:0] cnt_q;

  logic        sink_q;
  logic [31:0] seq_q;
  logic [31:0] stat_q [StatCount];

  // result registers
  logic               done_q;
  logic               ok_q;
  logic               adm_q;
  logic [31:0]        seq_out_q;
  logic [7:0]         pid_out_q;
  logic [15:0]        addr_out_q;
  logic [15:0]        len_out_q;
  logic signed [15:0] rssi_out_q;
  logic [7:0]         kind_out_q;
  logic [31:0]        cval_q;

  // table connections
  logic            rd_en;
  entry_t          rd_entry;
  logic            rd_used;
  tbl_cmd_t        wr_cmd;
  logic [IdxW-1:0] wr_idx;
  entry_t          wr_entry;

  logic                 accept_req;
  logic [31:0]          delta;
  logic                 expired;
  logic                 over;
  logic                 rate_run;
  logic                 up_adm;
  logic                 dn_pass;
  logic [StatCount-1:0] stat_inc;
  logic                 do_clear;

  ptg_table #(
    .NumPorts (NumPorts),
    .IdxW     (IdxW)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_idx_i   (rd_idx_q),
    .rd_entry_o (rd_entry),
    .rd_used_o  (rd_used),
    .wr_cmd_i   (wr_cmd),
    .wr_idx_i   (wr_idx),
    .wr_entry_i (wr_entry)
  );

  assign busy_o     = (state_q != StIdle);
  assign accept_req = start_i && !busy_o;
  assign rd_en      = (state_q == StScan) && !issue_done_q;

  // window arithmetic on the matched entry
  assign delta   = now_q - hit_ent_q.win_start;
  assign expired = (delta >= WindowMs);

  // rate decision and admission
  assign rate_run = hit_q && sink_q && (hit_ent_q.cap != 16'd0);
  assign over     = rate_run && (cnt_q >= hit_ent_q.cap);
  assign up_adm   = hit_q && sink_q && !over;
  assign dn_pass  = hit_q && hit_ent_q.can_send && accept_q;
  assign do_clear = (state_q == StDecide) && (act_q == ActClear);

  // table write selection
  always_comb begin
    wr_cmd   = '0;
    wr_idx   = hit_idx_q;
    wr_entry = hit_ent_q;
    if (state_q == StDecide) begin
      case (act_q)
        ActAdd: begin
          if (!hit_q && free_q) begin
            wr_cmd.en          = 1'b1;
            wr_cmd.alloc       = 1'b1;
            wr_idx             = free_idx_q;
            wr_entry.id        = pid_q;
            wr_entry.kind      = kind_q;
            wr_entry.can_send  = tx_q;
            wr_entry.cap       = cap_q;
            wr_entry.win_start = '0;
            wr_entry.count     = '0;
          end
        end
        ActUplink: begin
          if (rate_run) begin
            wr_cmd.en          = 1'b1;
            wr_entry.win_start = win_q;
            wr_entry.count     = over ? cnt_q : cnt_q + 16'd1;
          end
        end
        ActClear: begin
          wr_cmd.clear = 1'b1;
        end
        default: begin
          wr_cmd = '0;
        end
      endcase
    end
  end

  // statistic increments
  always_comb begin
    stat_inc = '0;
    if (state_q == StDecide) begin
      case (act_q)
        ActUplink: begin
          stat_inc[StatUpIn]   = 1'b1;
          stat_inc[StatUpPub]  = up_adm && accept_q;
          stat_inc[StatUpDrop] = !(up_adm && accept_q);
        end
        ActDownlink: begin
          stat_inc[StatDnIn]   = 1'b1;
          stat_inc[StatDnSent] = dn_pass;
          stat_inc[StatDnDrop] = !dn_pass;
        end
        default: begin
          stat_inc = '0;
        end
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept_req) begin
          if (action_i == ActAdd || action_i == ActUplink || action_i == ActDownlink) begin
            state_d = StScan;
          end else begin
            state_d = StDecide;
          end
        end
      end
      StScan: begin
        if (cmp_vld_q && cmp_idx_q == LastIdx) begin
          state_d = StWindow;
        end
      end
      StWindow: state_d = StDecide;
      StDecide: state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (accept_req) begin
      act_q    <= action_i;
      pid_q    <= port_id_i;
      addr_q   <= node_addr_i;
      len_q    <= payload_len_i;
      rssi_q   <= signal_rssi_i;
      now_q    <= now_ms_i;
      cap_q    <= cap_per_second_i;
      kind_q   <= kind_code_i;
      tx_q     <= has_transmitter_i;
      accept_q <= sink_accepts_i;
      sel_q    <= counter_select_i;
    end
  end

  // table scan, compare one entry per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q     <= '0;
      issue_done_q <= 1'b0;
      cmp_vld_q    <= 1'b0;
      cmp_idx_q    <= '0;
      hit_q        <= 1'b0;
      hit_idx_q    <= '0;
      free_q       <= 1'b0;
      free_idx_q   <= '0;
    end else if (accept_req) begin
      rd_idx_q     <= '0;
      issue_done_q <= 1'b0;
      cmp_vld_q    <= 1'b0;
      hit_q        <= 1'b0;
      free_q       <= 1'b0;
    end else if (state_q == StScan) begin
      cmp_vld_q <= rd_en;
      if (rd_en) begin
        cmp_idx_q <= rd_idx_q;
        if (rd_idx_q == LastIdx) begin
          issue_done_q <= 1'b1;
        end else begin
          rd_idx_q <= rd_idx_q + IdxW'(1);
        end
      end
      if (cmp_vld_q) begin
        if (rd_used && rd_entry.id == pid_q && !hit_q) begin
          hit_q     <= 1'b1;
          hit_idx_q <= cmp_idx_q;
        end
        if (!rd_used && !free_q) begin
          free_q     <= 1'b1;
          free_idx_q <= cmp_idx_q;
        end
      end
    end
  end

  // matched entry copy and window restart
  always_ff @(posedge clk_i) begin
    if (state_q == StScan && cmp_vld_q && rd_used && rd_entry.id == pid_q && !hit_q) begin
      hit_ent_q <= rd_entry;
    end
    if (state_q == StWindow) begin
      win_q <= expired ? now_q : hit_ent_q.win_start;
      cnt_q <= expired ? 16'd0 : hit_ent_q.count;
    end
  end

  // sink register, sequence and statistics
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sink_q <= 1'b0;
      seq_q  <= '0;
      for (int k = 0; k < StatCount; k++) begin
        stat_q[k] <= '0;
      end
    end else begin
      if (do_clear) begin
        sink_q <= 1'b0;
        seq_q  <= '0;
      end else begin
        if (cfg_we_i) begin
          sink_q <= cfg_wdata_i;
        end
        if (state_q == StDecide && act_q == ActUplink && up_adm) begin
          seq_q <= seq_q + 32'd1;
        end
      end
      for (int k = 0; k < StatCount; k++) begin
        if (do_clear) begin
          stat_q[k] <= '0;
        end else if (stat_inc[k]) begin
          stat_q[k] <= stat_q[k] + 32'd1;
        end
      end
    end
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (state_q == StDecide);
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (state_q == StDecide) begin
      ok_q       <= 1'b0;
      adm_q      <= 1'b0;
      seq_out_q  <= '0;
      pid_out_q  <= '0;
      addr_out_q <= '0;
      len_out_q  <= '0;
      rssi_out_q <= '0;
      kind_out_q <= '0;
      cval_q     <= '0;
      case (act_q)
        ActAdd: ok_q <= !hit_q && free_q;
        ActUplink: begin
          if (up_adm) begin
            ok_q       <= accept_q;
            adm_q      <= 1'b1;
            seq_out_q  <= seq_q;
            pid_out_q  <= pid_q;
            addr_out_q <= addr_q;
            len_out_q  <= len_q;
            rssi_out_q <= rssi_q;
            kind_out_q <= hit_ent_q.kind;
          end
        end
        ActDownlink: ok_q <= dn_pass;
        ActRead: begin
          if (32'(sel_q) < StatCount) begin
            cval_q <= stat_q[sel_q];
          end
        end
        default: begin
          ok_q <= 1'b0;
        end
      endcase
    end
  end

  assign done_o          = done_q;
  assign ok_o            = ok_q;
  assign admitted_o      = adm_q;
  assign seq_number_o    = seq_out_q;
  assign out_port_id_o   = pid_out_q;
  assign out_addr_o      = addr_out_q;
  assign out_len_o       = len_out_q;
  assign out_rssi_o      = rssi_out_q;
  assign out_kind_o      = kind_out_q;
  assign counter_value_o = cval_q;

endmodule

FILE: hw/rtl/ptg_table.sv
module ptg_table import ptg_pkg::*; #(
  parameter int unsigned NumPorts = NumPortsDef,
  parameter int unsigned IdxW     = (NumPorts > 1) ? $clog2(NumPorts) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_en_i,
  input  logic [IdxW-1:0] rd_idx_i,
  output entry_t          rd_entry_o,
  output logic            rd_used_o,
  input  tbl_cmd_t        wr_cmd_i,
  input  logic [IdxW-1:0] wr_idx_i,
  input  entry_t          wr_entry_i
);

  entry_t              mem [NumPorts];
  logic [NumPorts-1:0] used_q;
  entry_t              rd_entry_q;
  logic                rd_used_q;

  // entry storage, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_cmd_i.en) begin
      mem[wr_idx_i] <= wr_entry_i;
    end
    if (rd_en_i) begin
      rd_entry_q <= mem[rd_idx_i];
    end
  end

  // occupancy bits, cleared at once by reset or clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      rd_used_q <= 1'b0;
    end else begin
      if (wr_cmd_i.clear) begin
        used_q <= '0;
      end else if (wr_cmd_i.en && wr_cmd_i.alloc) begin
        used_q[wr_idx_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_used_q <= used_q[rd_idx_i];
      end
    end
  end

  assign rd_entry_o = rd_entry_q;
  assign rd_used_o  = rd_used_q;

endmodule

FILE: hw/rtl/ptg_checker.sv
module ptg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic        ok_o,
  input logic        admitted_o,
  input logic [31:0] seq_number_o,
  input logic [7:0]  out_kind_o,
  input logic [31:0] counter_value_o
);

  // an accepted request keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("request accepted but block not busy");

  // the result appears only once the block is free again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // no two results in consecutive cycles
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("back to back result strobes");

  // sequence number and kind fields are clear without admission
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !admitted_o |-> seq_number_o == 32'd0 && out_kind_o == 8'd0)
    else $error("envelope fields set on a refused request");

  // a counter read carries no success or envelope
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && counter_value_o != 32'd0 |-> !ok_o && !admitted_o)
    else $error("counter value on a non-read result");

endmodule

bind port_table_rate_limited_gateway_unit ptg_checker u_ptg_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .done_o          (done_o),
  .ok_o            (ok_o),
  .admitted_o      (admitted_o),
  .seq_number_o    (seq_number_o),
  .out_kind_o      (out_kind_o),
  .counter_value_o (counter_value_o)
);

FILE: tb/tb_port_table_rate_limited_gateway_unit.sv
module tb_port_table_rate_limited_gateway_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ptg_pkg::*;

  // action and selector codes outside the defined set
  localparam logic [2:0] ActUnusedLo = 3'd5;
  localparam logic [2:0] ActUnusedHi = 3'd7;
  localparam logic [2:0] SelUnused   = 3'd7;

  localparam int unsigned SettleCycles = NumPortsDef + 8;
  localparam int unsigned TargetItems  = 700;

  // one request as presented on the input ports
  typedef struct {
    logic [2:0]         action;
    logic [7:0]         port_id;
    logic [15:0]        node_addr;
    logic [15:0]        payload_len;
    logic signed [15:0] rssi;
    logic [31:0]        now_ms;
    logic [15:0]        cap;
    logic [7:0]         kind;
    logic               tx;
    logic               accept;
    logic [2:0]         sel;
  } gw_req_t;

  // one result as seen on the output ports
  typedef struct {
    logic               ok;
    logic               admitted;
    logic [31:0]        seq;
    logic [7:0]         port_id;
    logic [15:0]        addr;
    logic [15:0]        len;
    logic signed [15:0] rssi;
    logic [7:0]         kind;
    logic [31:0]        cval;
  } gw_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;
  logic start_i = 1'b0;
  logic busy_o, done_o, ok_o, admitted_o;
  logic [31:0] seq_number_o, counter_value_o;
  logic [7:0] out_port_id_o, out_kind_o;
  logic [15:0] out_addr_o, out_len_o;
  logic signed [15:0] out_rssi_o;

  gw_req_t drv_req = '{default: '0};
  gw_req_t pending_reqs[$];
  gw_res_t expected_results[$];

  // predicted block state
  entry_t      port_tbl [NumPortsDef];
  logic        port_used [NumPortsDef];
  logic [31:0] seq_ctr;
  logic [31:0] stat_tbl [StatCount];
  logic        sink_on;

  // handshake bookkeeping between driver and monitor
  bit req_busy = 1'b0;
  bit req_taken = 1'b0;
  int unsigned idle_pct = 33;
  int unsigned items_queued = 0;
  int unsigned results_seen = 0;
  int unsigned uplinks_admitted = 0;
  int unsigned phase_cnt = 0;
  int unsigned errs = 0;
  logic [31:0] clock_ms;
  logic [7:0] id_pool [12];

  port_table_rate_limited_gateway_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .action_i         (drv_req.action),
    .port_id_i        (drv_req.port_id),
    .node_addr_i      (drv_req.node_addr),
    .payload_len_i    (drv_req.payload_len),
    .signal_rssi_i    (drv_req.rssi),
    .now_ms_i         (drv_req.now_ms),
    .cap_per_second_i (drv_req.cap),
    .kind_code_i      (drv_req.kind),
    .has_transmitter_i(drv_req.tx),
    .sink_accepts_i   (drv_req.accept),
    .counter_select_i (drv_req.sel),
    .done_o           (done_o),
    .ok_o             (ok_o),
    .admitted_o       (admitted_o),
    .seq_number_o     (seq_number_o),
    .out_port_id_o    (out_port_id_o),
    .out_addr_o       (out_addr_o),
    .out_len_o        (out_len_o),
    .out_rssi_o       (out_rssi_o),
    .out_kind_o       (out_kind_o),
    .counter_value_o  (counter_value_o)
  );

  // clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // hard stop
  initial begin
    #4_000_000;
    $display("tb_port_table_rate_limited_gateway_unit: errors");
    $finish;
  end

  // clear the predicted state, as reset and the clear action do
  function automatic void reset_model();
    int i;
    for (i = 0; i < NumPortsDef; i++) begin
      port_tbl[i] = '0;
      port_used[i] = 1'b0;
    end
    for (i = 0; i < StatCount; i++) stat_tbl[i] = '0;
    seq_ctr = '0;
    sink_on = 1'b0;
  endfunction

  // work out the result of one request and advance the predicted state
  function automatic gw_res_t predict_gateway(input gw_req_t r);
    gw_res_t e;
    int i;
    int slot;
    int free_slot;
    logic refused;
    e = '{default: '0};
    slot = -1;
    free_slot = -1;
    for (i = 0; i < NumPortsDef; i++) begin
      if (port_used[i] && port_tbl[i].id == r.port_id && slot < 0) slot = i;
      if (!port_used[i] && free_slot < 0) free_slot = i;
    end
    case (r.action)
      ActAdd: begin
        if (slot < 0 && free_slot >= 0) begin
          port_used[free_slot] = 1'b1;
          port_tbl[free_slot] = '{id: r.port_id, kind: r.kind, can_send: r.tx, cap: r.cap,
                                  win_start: '0, count: '0};
          e.ok = 1'b1;
        end
      end
      ActUplink: begin
        stat_tbl[StatUpIn] += 1;
        refused = (slot < 0) || !sink_on;
        // fixed window: restart after a full second, refuse once the cap is reached
        if (!refused && port_tbl[slot].cap != '0) begin
          if (r.now_ms - port_tbl[slot].win_start >= WindowMs) begin
            port_tbl[slot].win_start = r.now_ms;
            port_tbl[slot].count = '0;
          end
          if (port_tbl[slot].count >= port_tbl[slot].cap) refused = 1'b1;
          else port_tbl[slot].count += 1;
        end
        if (refused) begin
          stat_tbl[StatUpDrop] += 1;
        end else begin
          e.admitted = 1'b1;
          e.seq = seq_ctr;
          seq_ctr += 1;
          e.port_id = r.port_id;
          e.addr = r.node_addr;
          e.len = r.payload_len;
          e.rssi = r.rssi;
          e.kind = port_tbl[slot].kind;
          // sequence number is spent even when the sink refuses
          if (r.accept) begin
            stat_tbl[StatUpPub] += 1;
            e.ok = 1'b1;
          end else begin
            stat_tbl[StatUpDrop] += 1;
          end
        end
      end
      ActDownlink: begin
        stat_tbl[StatDnIn] += 1;
        if (slot >= 0 && port_tbl[slot].can_send && r.accept) begin
          stat_tbl[StatDnSent] += 1;
          e.ok = 1'b1;
        end else begin
          stat_tbl[StatDnDrop] += 1;
        end
      end
      ActRead: begin
        if (r.sel < StatCount) e.cval = stat_tbl[r.sel];
      end
      ActClear: begin
        reset_model();
      end
      default: begin
      end
    endcase
    return e;
  endfunction

  // request with every field random
  function automatic gw_req_t rand_req();
    gw_req_t r;
    r.action = 3'($urandom);
    r.port_id = 8'($urandom);
    r.node_addr = 16'($urandom);
    r.payload_len = 16'($urandom);
    r.rssi = 16'($urandom);
    r.now_ms = $urandom;
    r.cap = 16'($urandom);
    r.kind = 8'($urandom);
    r.tx = 1'($urandom);
    r.accept = 1'($urandom);
    r.sel = 3'($urandom);
    return r;
  endfunction

  function automatic gw_req_t base_req(input logic [2:0] act, input logic [7:0] id);
    gw_req_t r;
    r = rand_req();
    r.action = act;
    r.port_id = id;
    return r;
  endfunction

  function automatic void queue_req(input gw_req_t r);
    pending_reqs.push_back(r);
    items_queued++;
  endfunction

  // driver: present the next request at the falling edge, hold it until taken
  always @(negedge clk_i) begin
    if (req_taken) begin
      req_busy = 1'b0;
      req_taken = 1'b0;
    end
    if (rst_ni && !req_busy && pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
      drv_req = pending_reqs.pop_front();
      req_busy = 1'b1;
    end
    start_i <= req_busy;
  end

  // monitor: check results, track register writes, predict on acceptance
  always @(posedge clk_i) begin : mon
    gw_res_t got;
    gw_res_t want;
    if (rst_ni) begin
      if (done_o) begin
        got = '{ok: ok_o, admitted: admitted_o, seq: seq_number_o, port_id: out_port_id_o,
                addr: out_addr_o, len: out_len_o, rssi: out_rssi_o, kind: out_kind_o,
                cval: counter_value_o};
        results_seen++;
        if (admitted_o) uplinks_admitted++;
        if (expected_results.size() == 0) begin
          errs++;
          if (errs <= 10) $display("%0t: result with no request waiting: %p", $realtime, got);
        end else begin
          want = expected_results.pop_front();
          if (got.ok !== want.ok || got.admitted !== want.admitted || got.seq !== want.seq ||
              got.port_id !== want.port_id || got.addr !== want.addr ||
              got.len !== want.len || got.rssi !== want.rssi ||
              got.kind !== want.kind || got.cval !== want.cval) begin
            errs++;
            if (errs <= 10)
              $display("%0t: result %0d mismatch\n  expected %p\n  actual   %p",
                       $realtime, results_seen, want, got);
          end
        end
      end
      if (cfg_we_i) sink_on = cfg_wdata_i;
      if (start_i && !busy_o) begin
        expected_results.push_back(predict_gateway(drv_req));
        req_taken = 1'b1;
      end
    end
  end

  // wait until every request is taken and answered, then let the block go quiet
  task automatic settle();
    while (pending_reqs.size() > 0 || req_busy || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_sink(input logic v);
    settle();
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // random traffic for one phase; a clear ends the phase so the sink can be rewritten
  task automatic queue_random(input int unsigned n);
    gw_req_t r;
    int unsigned k;
    int unsigned pick;
    for (k = 0; k < n; k++) begin
      r = rand_req();
      pick = $urandom_range(99);
      if (pick < 14) r.action = ActAdd;
      else if (pick < 58) r.action = ActUplink;
      else if (pick < 76) r.action = ActDownlink;
      else if (pick < 90) r.action = ActRead;
      else if (pick < 92) r.action = ActClear;
      else if (pick < 95) r.action = 3'($urandom_range(ActUnusedLo, ActUnusedHi));
      if ($urandom_range(99) < 88) r.port_id = id_pool[$urandom_range(11)];
      // time mostly creeps forward so windows both fill and roll over
      pick = $urandom_range(99);
      if (pick < 3) clock_ms = $urandom;
      else if (pick < 5) clock_ms = 32'hFFFF_FFFF - $urandom_range(1500);
      else clock_ms += $urandom_range(350);
      r.now_ms = ($urandom_range(99) < 2) ? $urandom : clock_ms;
      pick = $urandom_range(99);
      if (pick < 70) r.cap = 16'($urandom_range(1, 4));
      else if (pick < 85) r.cap = '0;
      r.accept = ($urandom_range(99) < 80);
      queue_req(r);
      if (r.action == ActClear) break;
    end
  endtask

  // stimulus
  initial begin : stim
    gw_req_t r;
    int unsigned k;
    int unsigned w;
    reset_model();
    clock_ms = $urandom;
    for (k = 0; k < 12; k++) id_pool[k] = 8'($urandom);
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: sink off after reset
    write_sink(1'b0);
    r = base_req(ActRead, 8'h00);
    r.sel = SelUnused;
    queue_req(r);
    r = base_req(ActAdd, 8'h00);
    r.kind = 8'hFF;
    r.tx = 1'b1;
    r.cap = 16'd2;
    queue_req(r);
    queue_req(base_req(ActUplink, 8'h00));
    queue_req(base_req(ActUnusedLo, 8'h00));

    // directed: sink on, fill the table, walk one window, downlinks
    write_sink(1'b1);
    r = base_req(ActAdd, 8'hFF);
    r.kind = 8'h00;
    r.tx = 1'b0;
    r.cap = 16'd0;
    queue_req(r);
    queue_req(base_req(ActAdd, 8'h00));
    for (k = 1; k <= 6; k++) queue_req(base_req(ActAdd, 8'(k)));
    queue_req(base_req(ActAdd, 8'h07));
    r = base_req(ActUplink, 8'h00);
    r.now_ms = 32'd0;
    r.accept = 1'b1;
    r.node_addr = 16'hFFFF;
    r.payload_len = 16'hFFFF;
    r.rssi = 16'sh8000;
    queue_req(r);
    r = base_req(ActUplink, 8'h00);
    r.now_ms = 32'd999;
    r.accept = 1'b0;
    queue_req(r);
    r.accept = 1'b1;
    queue_req(r);
    r = base_req(ActUplink, 8'h00);
    r.now_ms = 32'd1000;
    r.accept = 1'b1;
    r.node_addr = '0;
    r.payload_len = '0;
    r.rssi = '0;
    queue_req(r);
    r = base_req(ActUplink, 8'hFF);
    r.now_ms = 32'hFFFF_FFFF;
    r.rssi = 16'sh7FFF;
    r.accept = 1'b1;
    queue_req(r);
    queue_req(base_req(ActUplink, 8'h80));
    r = base_req(ActDownlink, 8'h00);
    r.accept = 1'b1;
    queue_req(r);
    r.accept = 1'b0;
    queue_req(r);
    r = base_req(ActDownlink, 8'hFF);
    r.accept = 1'b1;
    queue_req(r);
    r = base_req(ActRead, 8'h00);
    r.sel = 3'(StatUpDrop);
    queue_req(r);
    queue_req(base_req(ActClear, 8'h00));

    // random phases, sender gaps rising and then dropping to none
    while (items_queued < TargetItems) begin
      if (items_queued < TargetItems / 3) idle_pct = 33;
      else if (items_queued < 2 * TargetItems / 3) idle_pct = 59;
      else idle_pct = 0;
      write_sink((phase_cnt % 4 == 3) ? 1'b0 : 1'b1);
      queue_random((TargetItems - items_queued < 100) ? TargetItems - items_queued : 100);
      phase_cnt++;
    end

    // drain, with a bound in case results stop coming
    w = 0;
    while ((pending_reqs.size() > 0 || req_busy || expected_results.size() > 0) && w < 20000) begin
      @(posedge clk_i);
      w++;
    end
    repeat (SettleCycles) @(posedge clk_i);
    if (pending_reqs.size() > 0 || req_busy || expected_results.size() > 0) begin
      errs++;
      $display("%0d requests still unanswered at end of run", expected_results.size());
    end

    $display("run covered %0d requests in %0d random phases, %0d results checked",
             items_queued, phase_cnt, results_seen);
    $display("%0d uplinks admitted, %0d mismatches", uplinks_admitted, errs);
    if (errs == 0) begin
      $display("tb_port_table_rate_limited_gateway_unit: clean");
    end else begin
      $display("tb_port_table_rate_limited_gateway_unit: errors");
    end
    $finish;
  end

endmodule
